@@ hw/rtl/bu2x_pkg.sv @@
// bu2x_pkg: shared widths, defaults, register indexes and the emit phase type
// for the 2x bilinear upscaler. No dependencies.
package bu2x_pkg;

    localparam int PIX_W        = 8;
    localparam int OUT_W        = 11;
    localparam int CFG_W        = 11;
    localparam int CFG_IDX_W    = 1;
    localparam int DEF_MAX_COLS = 1024;
    localparam int DEF_MAX_ROWS = 1024;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS = 1'd1;

    localparam logic [CFG_W-1:0] RST_IMAGE_COLS = 11'd1024;
    localparam logic [CFG_W-1:0] RST_IMAGE_ROWS = 11'd1024;

    // which of the up to four output words is being shown
    typedef enum logic [3:0] {
        PH_DIAG = 4'b0001,
        PH_VERT = 4'b0010,
        PH_HORZ = 4'b0100,
        PH_COPY = 4'b1000
    } t_phase;

endpackage

@@ hw/rtl/bilinear_upscale_2x.sv @@
// bilinear_upscale_2x: 2x bilinear upscaler of an 8-bit grey raster stream.
// Uses bu2x_pkg; holds the previous source row in one on-chip line memory.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) takes one source pixel word per
//   accepted cycle in raster order; i_frame_start restarts at row 0, col 0.
//   Output channel (o_out_valid / i_out_stall) gives one upscaled pixel word
//   per cycle while i_out_stall is low, with its row and column; o_last_of_run
//   marks the copied original, the last word caused by a source pixel.
//   Pixel (i,j) gives 4 words when i>0 and j>0, 2 words on the first row or
//   first column but not both, 1 word at (0,0).
// Path: an accepted pixel is registered in the read stage, then in the emit stage.
// Throughput: one output word per cycle while i_out_stall is low; a source
//   pixel's 1 to 4 words are shown in turn by the emit stage registers. The line
//   memory read and the next pixel's acceptance overlap the current output.
// Stall: the output word holds while i_out_stall is high; one more pixel may
//   wait in the read stage, then o_in_stall rises.
// Reset: position, neighbor pixels and pipeline go to zero/empty; image_cols
//   and image_rows go to 1024. The line memory is not cleared.
// Config (i_cfg_we, i_cfg_idx, i_cfg_data) must be written only while idle; the block does not enforce this.
module bilinear_upscale_2x #(
    parameter int MAX_COLS = bu2x_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = bu2x_pkg::DEF_MAX_ROWS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bu2x_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [bu2x_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [bu2x_pkg::PIX_W-1:0]     i_pixel_value,
    input  logic                           i_frame_start,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [bu2x_pkg::OUT_W-1:0]     o_out_row,
    output logic [bu2x_pkg::OUT_W-1:0]     o_out_col,
    output logic [bu2x_pkg::PIX_W-1:0]     o_out_value,
    output logic                           o_last_of_run
);
    import bu2x_pkg::*;

    localparam int CW     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RW     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CDIM_W = (CFG_W > $clog2(MAX_COLS + 1)) ? CFG_W : $clog2(MAX_COLS + 1);
    localparam int RDIM_W = (CFG_W > $clog2(MAX_ROWS + 1)) ? CFG_W : $clog2(MAX_ROWS + 1);

    // configuration
    logic [CFG_W-1:0]  r_cols, r_rows;
    logic [CDIM_W-1:0] cols_raw, cols_eff;
    logic [RDIM_W-1:0] rows_raw, rows_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= RST_IMAGE_COLS;
            r_rows <= RST_IMAGE_ROWS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_IMAGE_COLS: r_cols <= i_cfg_data;
                REG_IMAGE_ROWS: r_rows <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        cols_raw = CDIM_W'(r_cols);
        rows_raw = RDIM_W'(r_rows);
        if (cols_raw == '0)                     cols_eff = CDIM_W'(1);
        else if (cols_raw > CDIM_W'(MAX_COLS))  cols_eff = CDIM_W'(MAX_COLS);
        else                                    cols_eff = cols_raw;
        if (rows_raw == '0)                     rows_eff = RDIM_W'(1);
        else if (rows_raw > RDIM_W'(MAX_ROWS))  rows_eff = RDIM_W'(MAX_ROWS);
        else                                    rows_eff = rows_raw;
    end

    // handshake
    logic   r_s1_valid, r_e_valid;
    t_phase r_phase, n_phase, first_phase;
    logic   out_take, e_done, e_load, in_take;

    assign out_take   = r_e_valid && !i_out_stall;
    assign e_done     = out_take && (r_phase == PH_COPY);
    assign e_load     = r_s1_valid && (!r_e_valid || e_done);
    assign o_in_stall = r_s1_valid && !e_load;
    assign in_take    = i_in_valid && !o_in_stall;

    // position of the incoming word
    logic [RW-1:0]     r_row, cur_i;
    logic [CW-1:0]     r_col, cur_j;
    logic [CDIM_W-1:0] j_next;
    logic [RDIM_W-1:0] i_next;

    assign cur_i  = i_frame_start ? '0 : r_row;
    assign cur_j  = i_frame_start ? '0 : r_col;
    assign j_next = CDIM_W'(cur_j) + CDIM_W'(1);
    assign i_next = RDIM_W'(cur_i) + RDIM_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (in_take) begin
            if (j_next >= cols_eff) begin
                r_col <= '0;
                r_row <= (i_next >= rows_eff) ? '0 : RW'(i_next);
            end else begin
                r_col <= CW'(j_next);
                r_row <= cur_i;
            end
        end
    end

    // line memory: read-first, so the read sees the previous row's word
    logic [PIX_W-1:0] mem_row [MAX_COLS];
    logic [PIX_W-1:0] r_mem_q;

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_mem_q        <= mem_row[cur_j];
            mem_row[cur_j] <= i_pixel_value;
        end
    end

    // read stage
    logic [PIX_W-1:0] r_s1_p;
    logic [RW-1:0]    r_s1_i;
    logic [CW-1:0]    r_s1_j;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_take) begin
            r_s1_valid <= 1'b1;
        end else if (e_load) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_p <= i_pixel_value;
            r_s1_i <= cur_i;
            r_s1_j <= cur_j;
        end
    end

    // emit stage
    logic [PIX_W-1:0] r_left, r_ul;
    logic [PIX_W-1:0] r_e_p, r_e_above, r_e_left, r_e_ul;
    logic [RW-1:0]    r_e_i;
    logic [CW-1:0]    r_e_j;
    logic             s1_i_nz, s1_j_nz, e_j_nz;

    assign s1_i_nz = (r_s1_i != '0);
    assign s1_j_nz = (r_s1_j != '0);
    assign e_j_nz  = (r_e_j != '0);

    always_comb begin
        if (s1_i_nz && s1_j_nz) first_phase = PH_DIAG;
        else if (s1_i_nz)       first_phase = PH_VERT;
        else if (s1_j_nz)       first_phase = PH_HORZ;
        else                    first_phase = PH_COPY;
    end

    always_comb begin
        n_phase = r_phase;
        if (e_load) begin
            n_phase = first_phase;
        end else if (out_take) begin
            unique case (r_phase)
                PH_DIAG: n_phase = PH_VERT;
                PH_VERT: n_phase = e_j_nz ? PH_HORZ : PH_COPY;
                PH_HORZ: n_phase = PH_COPY;
                default: n_phase = PH_COPY;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
            r_phase   <= PH_COPY;
            r_left    <= '0;
            r_ul      <= '0;
        end else begin
            r_phase <= n_phase;
            if (e_load) begin
                r_e_valid <= 1'b1;
                r_left    <= r_s1_p;
                r_ul      <= r_mem_q;
            end else if (e_done) begin
                r_e_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (e_load) begin
            r_e_p     <= r_s1_p;
            r_e_above <= r_mem_q;
            r_e_left  <= r_left;
            r_e_ul    <= r_ul;
            r_e_i     <= r_s1_i;
            r_e_j     <= r_s1_j;
        end
    end

    // output word
    logic [PIX_W+1:0] sum4;
    logic [PIX_W:0]   sum_v, sum_h;
    logic [OUT_W-1:0] row2, col2;

    assign sum4  = (PIX_W+2)'(r_e_ul) + (PIX_W+2)'(r_e_above)
                 + (PIX_W+2)'(r_e_left) + (PIX_W+2)'(r_e_p);
    assign sum_v = (PIX_W+1)'(r_e_above) + (PIX_W+1)'(r_e_p);
    assign sum_h = (PIX_W+1)'(r_e_left) + (PIX_W+1)'(r_e_p);
    assign row2  = OUT_W'({r_e_i, 1'b0});
    assign col2  = OUT_W'({r_e_j, 1'b0});

    always_comb begin
        unique case (r_phase)
            PH_DIAG: begin
                o_out_row   = row2 - OUT_W'(1);
                o_out_col   = col2 - OUT_W'(1);
                o_out_value = sum4[PIX_W+1:2];
            end
            PH_VERT: begin
                o_out_row   = row2 - OUT_W'(1);
                o_out_col   = col2;
                o_out_value = sum_v[PIX_W:1];
            end
            PH_HORZ: begin
                o_out_row   = row2;
                o_out_col   = col2 - OUT_W'(1);
                o_out_value = sum_h[PIX_W:1];
            end
            default: begin
                o_out_row   = row2;
                o_out_col   = col2;
                o_out_value = r_e_p;
            end
        endcase
    end

    assign o_out_valid   = r_e_valid;
    assign o_last_of_run = (r_phase == PH_COPY);

endmodule
